// ===== hw/rtl/trs_to_affine_matrix_assert.svh =====
// Assertion macros for the checker file of the affine matrix block.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef TRS_TO_AFFINE_MATRIX_ASSERT_SVH
`define TRS_TO_AFFINE_MATRIX_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TRSAM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trsam: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define TRSAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trsam: next-cycle check failed");

`endif

// ===== hw/rtl/trsam_pkg.sv =====
// Shared types, widths and index constants of the TRS to affine matrix pipeline.
// No dependencies; the RTL and checker files refer to it by scoped names.
package trsam_pkg;

    // Field widths of the stream items.
    localparam int unsigned COMP_W  = 16;
    localparam int unsigned POS_W   = 32;
    localparam int unsigned PROD_W  = 32;
    localparam int unsigned ROT_W   = 34;
    localparam int unsigned MUL_W   = 50;
    localparam int unsigned OUT_W   = 24;
    localparam int unsigned RND_SH  = 20;
    localparam int unsigned IN_DW   = 208;
    localparam int unsigned OUT_DW  = 312;

    localparam int unsigned QUAT_N  = 4;
    localparam int unsigned AXIS_N  = 3;
    localparam int unsigned PROD_N  = 9;
    localparam int unsigned MAT_N   = 9;

    // Quaternion component indexes.
    localparam int unsigned Q_W = 0;
    localparam int unsigned Q_X = 1;
    localparam int unsigned Q_Y = 2;
    localparam int unsigned Q_Z = 3;

    // Product indexes.
    localparam int unsigned P_XX = 0;
    localparam int unsigned P_YY = 1;
    localparam int unsigned P_ZZ = 2;
    localparam int unsigned P_XY = 3;
    localparam int unsigned P_XZ = 4;
    localparam int unsigned P_YZ = 5;
    localparam int unsigned P_WX = 6;
    localparam int unsigned P_WY = 7;
    localparam int unsigned P_WZ = 8;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ROT_W-1:0]  rot_t;
    typedef logic signed [MUL_W-1:0]  mul_t;
    typedef logic signed [OUT_W-1:0]  ent_t;

    // 1.0 in the Q.28 rotation format.
    localparam rot_t ROT_ONE = rot_t'(1) <<< 28;
    // Half an output LSB in the Q.36 product format.
    localparam mul_t RND_HALF = mul_t'(1) <<< (RND_SH - 1);
    localparam ent_t ENT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam ent_t ENT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// ===== hw/rtl/trs_to_affine_matrix.sv =====
// Top level of the TRS to affine matrix pipeline.
// Depends on trsam_pkg, trsam_prod, trsam_rot and trsam_scl.
//
// Usage:
// The slave channel takes one transform per item: quaternion, three scales
// and three translations. The master channel gives one item per transform:
// the nine entries of R*S in Q8.16, saturated, then the translation column.
// The pipeline has four register stages: the product stage, the rotation
// stage, the scaling multiplier stage and the rounding stage that feeds the
// output register. It takes one item per cycle while the receiver does not
// stall; each stage holds one item and advances whenever the stage after it
// is empty or handing its item on.
// When the receiver stalls, the output item holds and the stages behind it
// fill up; s_axis_tready falls once all four stages hold an item, and no item
// is dropped or repeated. Reset clears all valid bits, so the block comes out
// of reset empty and ready. The block keeps no state between items.
module trs_to_affine_matrix (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // Fields from bit 0: quat_w, quat_x, quat_y, quat_z (16 each),
    // scale_x, scale_y, scale_z (16 each), pos_x, pos_y, pos_z (32 each).
    input  logic [trsam_pkg::IN_DW-1:0]  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // Fields from bit 0: m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
    // m_r2c0, m_r2c1, m_r2c2 (24 each), t_x, t_y, t_z (32 each).
    output logic [trsam_pkg::OUT_DW-1:0] m_axis_tdata
);

    trsam_pkg::comp_t quat      [trsam_pkg::QUAT_N];
    trsam_pkg::comp_t scale_in  [trsam_pkg::AXIS_N];
    trsam_pkg::pos_t  pos_in    [trsam_pkg::AXIS_N];

    logic             prod_valid;
    logic             prod_ready;
    trsam_pkg::prod_t prod      [trsam_pkg::PROD_N];
    trsam_pkg::comp_t prod_scale[trsam_pkg::AXIS_N];
    trsam_pkg::pos_t  prod_pos  [trsam_pkg::AXIS_N];

    logic             rot_valid;
    logic             rot_ready;
    trsam_pkg::rot_t  rot       [trsam_pkg::MAT_N];
    trsam_pkg::comp_t rot_scale [trsam_pkg::AXIS_N];
    trsam_pkg::pos_t  rot_pos   [trsam_pkg::AXIS_N];

    trsam_pkg::ent_t  ent       [trsam_pkg::MAT_N];
    trsam_pkg::pos_t  out_pos   [trsam_pkg::AXIS_N];

    // Unpack the input item.
    assign quat[trsam_pkg::Q_W] = s_axis_tdata[15:0];
    assign quat[trsam_pkg::Q_X] = s_axis_tdata[31:16];
    assign quat[trsam_pkg::Q_Y] = s_axis_tdata[47:32];
    assign quat[trsam_pkg::Q_Z] = s_axis_tdata[63:48];
    assign scale_in[0]          = s_axis_tdata[79:64];
    assign scale_in[1]          = s_axis_tdata[95:80];
    assign scale_in[2]          = s_axis_tdata[111:96];
    assign pos_in[0]            = s_axis_tdata[143:112];
    assign pos_in[1]            = s_axis_tdata[175:144];
    assign pos_in[2]            = s_axis_tdata[207:176];

    // Quaternion products.
    trsam_prod u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .quat      (quat),
        .scale_in  (scale_in),
        .pos_in    (pos_in),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .prod      (prod),
        .scale_out (prod_scale),
        .pos_out   (prod_pos)
    );

    // Rotation matrix entries.
    trsam_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .prod      (prod),
        .scale_in  (prod_scale),
        .pos_in    (prod_pos),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .rot       (rot),
        .scale_out (rot_scale),
        .pos_out   (rot_pos)
    );

    // Column scaling, rounding and the output register.
    trsam_scl u_scl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .rot       (rot),
        .scale_in  (rot_scale),
        .pos_in    (rot_pos),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ent       (ent),
        .pos_out   (out_pos)
    );

    // Pack the result item.
    assign m_axis_tdata = {out_pos[2], out_pos[1], out_pos[0],
                           ent[8], ent[7], ent[6], ent[5], ent[4],
                           ent[3], ent[2], ent[1], ent[0]};

endmodule

// ===== hw/rtl/trsam_prod.sv =====
// First pipeline stage: the nine quaternion component products.
// Depends on trsam_pkg.
module trsam_prod (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  trsam_pkg::comp_t  quat      [trsam_pkg::QUAT_N],
    input  trsam_pkg::comp_t  scale_in  [trsam_pkg::AXIS_N],
    input  trsam_pkg::pos_t   pos_in    [trsam_pkg::AXIS_N],
    output logic              out_valid,
    input  logic              out_ready,
    output trsam_pkg::prod_t  prod      [trsam_pkg::PROD_N],
    output trsam_pkg::comp_t  scale_out [trsam_pkg::AXIS_N],
    output trsam_pkg::pos_t   pos_out   [trsam_pkg::AXIS_N]
);

    logic             valid_reg;
    logic             load;
    trsam_pkg::prod_t prod_next  [trsam_pkg::PROD_N];
    trsam_pkg::prod_t prod_reg   [trsam_pkg::PROD_N];
    trsam_pkg::comp_t scale_reg  [trsam_pkg::AXIS_N];
    trsam_pkg::pos_t  pos_reg    [trsam_pkg::AXIS_N];

    // The stage advances when it is empty or its item moves on.
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_ready && in_valid;

    // Each product of two Q1.14 values is exact in Q.28.
    always_comb
    begin
        prod_next[trsam_pkg::P_XX] = quat[trsam_pkg::Q_X] * quat[trsam_pkg::Q_X];
        prod_next[trsam_pkg::P_YY] = quat[trsam_pkg::Q_Y] * quat[trsam_pkg::Q_Y];
        prod_next[trsam_pkg::P_ZZ] = quat[trsam_pkg::Q_Z] * quat[trsam_pkg::Q_Z];
        prod_next[trsam_pkg::P_XY] = quat[trsam_pkg::Q_X] * quat[trsam_pkg::Q_Y];
        prod_next[trsam_pkg::P_XZ] = quat[trsam_pkg::Q_X] * quat[trsam_pkg::Q_Z];
        prod_next[trsam_pkg::P_YZ] = quat[trsam_pkg::Q_Y] * quat[trsam_pkg::Q_Z];
        prod_next[trsam_pkg::P_WX] = quat[trsam_pkg::Q_W] * quat[trsam_pkg::Q_X];
        prod_next[trsam_pkg::P_WY] = quat[trsam_pkg::Q_W] * quat[trsam_pkg::Q_Y];
        prod_next[trsam_pkg::P_WZ] = quat[trsam_pkg::Q_W] * quat[trsam_pkg::Q_Z];
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg  <= prod_next;
            scale_reg <= scale_in;
            pos_reg   <= pos_in;
        end
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;
    assign scale_out = scale_reg;
    assign pos_out   = pos_reg;

endmodule

// ===== hw/rtl/trsam_rot.sv =====
// Second pipeline stage: the nine rotation matrix entries in Q.28.
// Depends on trsam_pkg.
module trsam_rot (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  trsam_pkg::prod_t  prod      [trsam_pkg::PROD_N],
    input  trsam_pkg::comp_t  scale_in  [trsam_pkg::AXIS_N],
    input  trsam_pkg::pos_t   pos_in    [trsam_pkg::AXIS_N],
    output logic              out_valid,
    input  logic              out_ready,
    output trsam_pkg::rot_t   rot       [trsam_pkg::MAT_N],
    output trsam_pkg::comp_t  scale_out [trsam_pkg::AXIS_N],
    output trsam_pkg::pos_t   pos_out   [trsam_pkg::AXIS_N]
);

    logic             valid_reg;
    logic             load;
    trsam_pkg::rot_t  p          [trsam_pkg::PROD_N];
    trsam_pkg::rot_t  rot_next   [trsam_pkg::MAT_N];
    trsam_pkg::rot_t  rot_reg    [trsam_pkg::MAT_N];
    trsam_pkg::comp_t scale_reg  [trsam_pkg::AXIS_N];
    trsam_pkg::pos_t  pos_reg    [trsam_pkg::AXIS_N];

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_ready && in_valid;

    // Products sign-extended to the entry width, so no sum can overflow.
    always_comb
    begin
        for (int i = 0; i < trsam_pkg::PROD_N; i++)
        begin
            p[i] = trsam_pkg::rot_t'(prod[i]);
        end
    end

    // Standard unit-quaternion rotation matrix, row-major.
    always_comb
    begin
        rot_next[0] = trsam_pkg::ROT_ONE
                      - ((p[trsam_pkg::P_YY] + p[trsam_pkg::P_ZZ]) <<< 1);
        rot_next[1] = (p[trsam_pkg::P_XY] - p[trsam_pkg::P_WZ]) <<< 1;
        rot_next[2] = (p[trsam_pkg::P_XZ] + p[trsam_pkg::P_WY]) <<< 1;
        rot_next[3] = (p[trsam_pkg::P_XY] + p[trsam_pkg::P_WZ]) <<< 1;
        rot_next[4] = trsam_pkg::ROT_ONE
                      - ((p[trsam_pkg::P_XX] + p[trsam_pkg::P_ZZ]) <<< 1);
        rot_next[5] = (p[trsam_pkg::P_YZ] - p[trsam_pkg::P_WX]) <<< 1;
        rot_next[6] = (p[trsam_pkg::P_XZ] - p[trsam_pkg::P_WY]) <<< 1;
        rot_next[7] = (p[trsam_pkg::P_YZ] + p[trsam_pkg::P_WX]) <<< 1;
        rot_next[8] = trsam_pkg::ROT_ONE
                      - ((p[trsam_pkg::P_XX] + p[trsam_pkg::P_YY]) <<< 1);
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rot_reg   <= rot_next;
            scale_reg <= scale_in;
            pos_reg   <= pos_in;
        end
    end

    assign out_valid = valid_reg;
    assign rot       = rot_reg;
    assign scale_out = scale_reg;
    assign pos_out   = pos_reg;

endmodule

// ===== hw/rtl/trsam_scl.sv =====
// Third and fourth pipeline stages: column scaling, then rounding to Q8.16
// with saturation into the output register. Depends on trsam_pkg.
module trsam_scl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  trsam_pkg::rot_t   rot      [trsam_pkg::MAT_N],
    input  trsam_pkg::comp_t  scale_in [trsam_pkg::AXIS_N],
    input  trsam_pkg::pos_t   pos_in   [trsam_pkg::AXIS_N],
    output logic              out_valid,
    input  logic              out_ready,
    output trsam_pkg::ent_t   ent      [trsam_pkg::MAT_N],
    output trsam_pkg::pos_t   pos_out  [trsam_pkg::AXIS_N]
);

    localparam int unsigned Q_WID = trsam_pkg::MUL_W - trsam_pkg::RND_SH;

    logic                   mul_valid_reg;
    logic                   out_valid_reg;
    logic                   mul_adv;
    logic                   out_adv;
    trsam_pkg::mul_t        mul_next     [trsam_pkg::MAT_N];
    trsam_pkg::mul_t        mul_reg      [trsam_pkg::MAT_N];
    trsam_pkg::pos_t        mul_pos_reg  [trsam_pkg::AXIS_N];
    trsam_pkg::mul_t        rnd_sum      [trsam_pkg::MAT_N];
    logic signed [Q_WID-1:0] rnd_q       [trsam_pkg::MAT_N];
    trsam_pkg::ent_t        ent_next     [trsam_pkg::MAT_N];
    trsam_pkg::ent_t        ent_reg      [trsam_pkg::MAT_N];
    trsam_pkg::pos_t        out_pos_reg  [trsam_pkg::AXIS_N];

    // Each stage advances when it is empty or the next one takes its item.
    assign out_adv  = !out_valid_reg || out_ready;
    assign mul_adv  = !mul_valid_reg || out_adv;
    assign in_ready = mul_adv;

    // Column c of the rotation is multiplied by scale c; exact in Q.36.
    always_comb
    begin
        for (int i = 0; i < trsam_pkg::MAT_N; i++)
        begin
            mul_next[i] = rot[i] * scale_in[i % trsam_pkg::AXIS_N];
        end
    end

    // Round half up, floor shift to Q8.16, then clamp to the 24-bit range.
    always_comb
    begin
        for (int i = 0; i < trsam_pkg::MAT_N; i++)
        begin
            rnd_sum[i] = mul_reg[i] + trsam_pkg::RND_HALF;
            rnd_q[i]   = rnd_sum[i][trsam_pkg::MUL_W-1:trsam_pkg::RND_SH];
            if ((rnd_q[i][Q_WID-1:trsam_pkg::OUT_W-1] == '0)
                || (rnd_q[i][Q_WID-1:trsam_pkg::OUT_W-1] == '1))
            begin
                ent_next[i] = rnd_q[i][trsam_pkg::OUT_W-1:0];
            end
            else if (rnd_q[i][Q_WID-1])
            begin
                ent_next[i] = trsam_pkg::ENT_MIN;
            end
            else
            begin
                ent_next[i] = trsam_pkg::ENT_MAX;
            end
        end
    end

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_adv)
            begin
                mul_valid_reg <= in_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    // Payload of both stages.
    always_ff @(posedge clk)
    begin
        if (mul_adv && in_valid)
        begin
            mul_reg     <= mul_next;
            mul_pos_reg <= pos_in;
        end
        if (out_adv && mul_valid_reg)
        begin
            ent_reg     <= ent_next;
            out_pos_reg <= mul_pos_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign ent       = ent_reg;
    assign pos_out   = out_pos_reg;

endmodule

// ===== hw/rtl/trsam_checker.sv =====
// Port-level checks of the TRS to affine matrix block, bound to its top level.
// Depends on trsam_pkg and trs_to_affine_matrix_assert.svh.
`include "trs_to_affine_matrix_assert.svh"

module trsam_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [trsam_pkg::IN_DW-1:0]  s_axis_tdata,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [trsam_pkg::OUT_DW-1:0] m_axis_tdata
);

    // A stalled result item stays offered and unchanged.
    `TRSAM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // An empty output register means the whole pipeline can take an item.
    `TRSAM_ASSERT_IMPLY(a_empty_ready, clk, rst_n, !m_axis_tvalid, s_axis_tready)

    // A result that appears after a gap passed through the pipeline without a stall.
    `TRSAM_ASSERT_IMPLY(a_latency, clk, rst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 4))

    // The x translation passes through unchanged.
    `TRSAM_ASSERT_IMPLY(a_pos_x, clk, rst_n, $rose(m_axis_tvalid), m_axis_tdata[247:216] == $past(s_axis_tdata[143:112], 4))

endmodule

bind trs_to_affine_matrix trsam_checker u_trsam_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
